FILE: sv/wav_pcm_stream_parser_assert.svh
// ----------------------------------------------------------------------------
// WAVE parser assertion macros
// Shared property forms for the parser checks, clocked on i_clk and held
// off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WAV_PCM_STREAM_PARSER_ASSERT_SVH
`define WAV_PCM_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication
`define WPP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wav parser check failed");

// Next-cycle implication
`define WPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wav parser check failed");

`endif

FILE: sv/wpp_pkg.sv
// ----------------------------------------------------------------------------
// WAVE parser package
// Result types, tags, item kinds and error codes shared by the parser files.
// ----------------------------------------------------------------------------
package wpp_pkg;

    // Chunk tags as little-endian words
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] SIGN_FLIP   = 16'h8000;
    localparam logic [31:0] FMT_MIN_LEN = 32'd16;

    // Item kinds
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [4:0] ERR_NONE       = 5'd0;
    localparam logic [4:0] ERR_RIFF_TAG   = 5'd1;
    localparam logic [4:0] ERR_WAVE_TAG   = 5'd2;
    localparam logic [4:0] ERR_CHUNK_SIZE = 5'd3;
    localparam logic [4:0] ERR_FMT_DUP    = 5'd4;
    localparam logic [4:0] ERR_FMT_SHORT  = 5'd5;
    localparam logic [4:0] ERR_DATA_DUP   = 5'd6;
    localparam logic [4:0] ERR_DATA_EARLY = 5'd7;
    localparam logic [4:0] ERR_FORMAT     = 5'd8;
    localparam logic [4:0] ERR_CHANNELS   = 5'd9;
    localparam logic [4:0] ERR_RATE       = 5'd10;
    localparam logic [4:0] ERR_BITS       = 5'd11;
    localparam logic [4:0] ERR_BLOCK      = 5'd12;
    localparam logic [4:0] ERR_BYTE_RATE  = 5'd13;
    localparam logic [4:0] ERR_NO_DATA    = 5'd14;
    localparam logic [4:0] ERR_DATA_ODD   = 5'd15;
    localparam logic [4:0] ERR_DATA_FRAME = 5'd16;
    localparam logic [4:0] ERR_TRUNCATED  = 5'd17;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] left;
        logic [15:0] right;
        logic [30:0] rate;
        logic [4:0]  err;
        logic        last;
    } t_result;

    // Up to two results caused by one accepted byte
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_step;

endpackage

FILE: sv/wpp_parser.sv
// ----------------------------------------------------------------------------
// WAVE parser core
// Walks the RIFF/WAVE byte stream one beat at a time, captures and checks
// the fmt fields, converts data bytes to frames and forms the final item.
// ----------------------------------------------------------------------------
module wpp_parser
    import wpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_file,
    output t_step      o_step
);

    typedef enum logic [3:0] {
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID,
        PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER,
        PH_FORMAT, PH_CHAN, PH_RATE, PH_BRATE, PH_BLOCK, PH_BITS,
        PH_SKIP, PH_DATA, PH_DEAD
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_cnt, n_cnt;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_rem, n_rem;
    logic [15:0] r_format, n_format;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_brate, n_brate;
    logic [15:0] r_block, n_block;
    logic [15:0] r_bits, n_bits;
    logic        r_fmt_seen, n_fmt_seen;
    logic        r_data_seen, n_data_seen;
    logic [7:0]  r_low, n_low;
    logic [15:0] r_left, n_left;
    logic [1:0]  r_sphase, n_sphase;
    logic [4:0]  r_err, n_err;
    logic [47:0] r_rate_prod;

    logic        w_take, w_wide, w_done;
    logic [31:0] w_field, w_rem_dec, w_sz;
    logic [15:0] w_v, w_exp_block;
    logic        w_frame_v;
    logic [15:0] w_fl, w_fr;
    logic [4:0]  w_code;
    logic [30:0] w_rate_out;
    logic        w_eof;

    // Expected byte rate, registered ahead of the bits field
    always_ff @(posedge i_clk) begin
        r_rate_prod <= 48'(r_rate) * 48'(r_block);
    end

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_rem       = r_rem;
        n_format    = r_format;
        n_chan      = r_chan;
        n_rate      = r_rate;
        n_brate     = r_brate;
        n_block     = r_block;
        n_bits      = r_bits;
        n_fmt_seen  = r_fmt_seen;
        n_data_seen = r_data_seen;
        n_low       = r_low;
        n_left      = r_left;
        n_sphase    = r_sphase;
        n_err       = r_err;
        w_frame_v   = 1'b0;
        w_fl        = 16'h0;
        w_fr        = 16'h0;
        w_v         = 16'h0;
        w_code      = ERR_NONE;
        w_rate_out  = 31'h0;
        w_eof       = i_accept && i_end_of_file;

        // Assemble little-endian fields
        w_take    = !(r_phase inside {PH_SKIP, PH_DATA, PH_DEAD});
        w_wide    = !(r_phase inside {PH_FORMAT, PH_CHAN, PH_BLOCK, PH_BITS});
        w_field   = ((r_cnt == 2'd0) ? 32'h0 : r_shift) |
                    (32'(i_in_byte) << {r_cnt, 3'b000});
        w_done    = w_wide ? (r_cnt == 2'd3) : (r_cnt != 2'd0);
        w_rem_dec = r_rem - 32'd1;
        w_sz      = w_field;
        w_exp_block = (r_chan == 16'd2) ? (w_field[15:0] >> 2) : (w_field[15:0] >> 3);

        if (i_accept) begin
            if (w_take) begin
                n_shift = w_field;
                n_cnt   = w_done ? 2'd0 : 2'(r_cnt + 2'd1);
            end
            case (r_phase)
                PH_RIFF: begin
                    if (w_done) begin
                        if (w_field != TAG_RIFF) begin
                            n_phase = PH_DEAD;
                            n_err   = ERR_RIFF_TAG;
                        end else begin
                            n_phase = PH_RSIZE;
                        end
                    end
                end
                PH_RSIZE: begin
                    if (w_done) n_phase = PH_WAVE;
                end
                PH_WAVE: begin
                    if (w_done) begin
                        if (w_field != TAG_WAVE) begin
                            n_phase = PH_DEAD;
                            n_err   = ERR_WAVE_TAG;
                        end else begin
                            n_phase = PH_CID;
                        end
                    end
                end
                PH_CID: begin
                    if (w_done) begin
                        if (w_field == TAG_FMT)       n_phase = PH_SZ_FMT;
                        else if (w_field == TAG_DATA) n_phase = PH_SZ_DATA;
                        else                          n_phase = PH_SZ_OTHER;
                    end
                end
                PH_SZ_FMT, PH_SZ_DATA, PH_SZ_OTHER: begin
                    // Check the chunk size against the chunk kind
                    if (w_done) begin
                        if (w_sz[31]) begin
                            n_phase = PH_DEAD;
                            n_err   = ERR_CHUNK_SIZE;
                        end else if (r_phase == PH_SZ_OTHER) begin
                            n_rem   = w_sz;
                            n_phase = (w_sz != 32'h0) ? PH_SKIP : PH_CID;
                        end else if (r_phase == PH_SZ_FMT) begin
                            if (r_fmt_seen) begin
                                n_phase = PH_DEAD;
                                n_err   = ERR_FMT_DUP;
                            end else if (w_sz < FMT_MIN_LEN) begin
                                n_phase = PH_DEAD;
                                n_err   = ERR_FMT_SHORT;
                            end else begin
                                n_fmt_seen = 1'b1;
                                n_rem      = w_sz;
                                n_phase    = PH_FORMAT;
                            end
                        end else begin
                            if (r_data_seen) begin
                                n_phase = PH_DEAD;
                                n_err   = ERR_DATA_DUP;
                            end else if (!r_fmt_seen) begin
                                n_phase = PH_DEAD;
                                n_err   = ERR_DATA_EARLY;
                            end else if (r_bits == 16'd16 && w_sz[0]) begin
                                n_phase = PH_DEAD;
                                n_err   = ERR_DATA_ODD;
                            end else if ((w_sz & (32'(r_block) - 32'd1)) != 32'h0) begin
                                n_phase = PH_DEAD;
                                n_err   = ERR_DATA_FRAME;
                            end else begin
                                n_data_seen = 1'b1;
                                n_rem       = w_sz;
                                n_sphase    = 2'd0;
                                n_phase     = (w_sz != 32'h0) ? PH_DATA : PH_CID;
                            end
                        end
                    end
                end
                PH_FORMAT, PH_CHAN, PH_RATE, PH_BRATE, PH_BLOCK, PH_BITS: begin
                    n_rem = w_rem_dec;
                    if (w_done) begin
                        case (r_phase)
                            PH_FORMAT: begin
                                n_format = w_field[15:0];
                                n_phase  = PH_CHAN;
                            end
                            PH_CHAN: begin
                                n_chan  = w_field[15:0];
                                n_phase = PH_RATE;
                            end
                            PH_RATE: begin
                                n_rate  = w_field;
                                n_phase = PH_BRATE;
                            end
                            PH_BRATE: begin
                                n_brate = w_field;
                                n_phase = PH_BLOCK;
                            end
                            PH_BLOCK: begin
                                n_block = w_field[15:0];
                                n_phase = PH_BITS;
                            end
                            default: begin
                                // Bits field closes the fmt header: validate it
                                n_bits = w_field[15:0];
                                if (r_format != 16'd1) begin
                                    n_phase = PH_DEAD;
                                    n_err   = ERR_FORMAT;
                                end else if (r_chan != 16'd1 && r_chan != 16'd2) begin
                                    n_phase = PH_DEAD;
                                    n_err   = ERR_CHANNELS;
                                end else if (r_rate == 32'h0 || r_rate[31]) begin
                                    n_phase = PH_DEAD;
                                    n_err   = ERR_RATE;
                                end else if (w_field[15:0] != 16'd8 &&
                                             w_field[15:0] != 16'd16) begin
                                    n_phase = PH_DEAD;
                                    n_err   = ERR_BITS;
                                end else if (r_block != w_exp_block) begin
                                    n_phase = PH_DEAD;
                                    n_err   = ERR_BLOCK;
                                end else if ({16'h0, r_brate} != r_rate_prod) begin
                                    n_phase = PH_DEAD;
                                    n_err   = ERR_BYTE_RATE;
                                end else begin
                                    n_phase = (w_rem_dec != 32'h0) ? PH_SKIP : PH_CID;
                                end
                            end
                        endcase
                    end
                end
                PH_SKIP: begin
                    n_rem = w_rem_dec;
                    if (w_rem_dec == 32'h0) n_phase = PH_CID;
                end
                PH_DATA: begin
                    n_rem = w_rem_dec;
                    if (w_rem_dec == 32'h0) n_phase = PH_CID;
                    // Convert sample bytes to frames
                    if (r_bits == 16'd8) begin
                        w_v = {i_in_byte, 8'h00};
                        if (r_chan == 16'd1) begin
                            w_frame_v = 1'b1;
                            w_fl      = w_v;
                            w_fr      = w_v;
                        end else if (r_sphase == 2'd0) begin
                            n_left   = w_v;
                            n_sphase = 2'd1;
                        end else begin
                            n_sphase  = 2'd0;
                            w_frame_v = 1'b1;
                            w_fl      = r_left;
                            w_fr      = w_v;
                        end
                    end else if (!r_sphase[0]) begin
                        n_low    = i_in_byte;
                        n_sphase = 2'(r_sphase + 2'd1);
                    end else begin
                        w_v = {i_in_byte, r_low} ^ SIGN_FLIP;
                        if (r_chan == 16'd1) begin
                            n_sphase  = 2'd0;
                            w_frame_v = 1'b1;
                            w_fl      = w_v;
                            w_fr      = w_v;
                        end else if (r_sphase == 2'd1) begin
                            n_left   = w_v;
                            n_sphase = 2'd2;
                        end else begin
                            n_sphase  = 2'd0;
                            w_frame_v = 1'b1;
                            w_fl      = r_left;
                            w_fr      = w_v;
                        end
                    end
                end
                default: begin
                    // Dead: hold until end of file
                end
            endcase
        end

        // Final verdict on the last byte, then start over
        if (w_eof) begin
            w_code = n_err;
            if (w_code == ERR_NONE) begin
                if (n_phase != PH_CID || n_cnt != 2'd0) w_code = ERR_TRUNCATED;
                else if (!n_data_seen)                   w_code = ERR_NO_DATA;
            end
            w_rate_out  = (w_code == ERR_NONE) ? n_rate[30:0] : 31'h0;
            n_phase     = PH_RIFF;
            n_cnt       = 2'd0;
            n_shift     = 32'h0;
            n_rem       = 32'h0;
            n_format    = 16'h0;
            n_chan      = 16'h0;
            n_rate      = 32'h0;
            n_brate     = 32'h0;
            n_block     = 16'h0;
            n_bits      = 16'h0;
            n_fmt_seen  = 1'b0;
            n_data_seen = 1'b0;
            n_low       = 8'h0;
            n_left      = 16'h0;
            n_sphase    = 2'd0;
            n_err       = ERR_NONE;
        end
    end

    // Pack the results of this beat
    always_comb begin
        t_result w_frame, w_final;
        w_frame.kind  = KIND_FRAME;
        w_frame.left  = w_fl;
        w_frame.right = w_fr;
        w_frame.rate  = 31'h0;
        w_frame.err   = ERR_NONE;
        w_frame.last  = !w_eof;
        w_final.kind  = (w_code == ERR_NONE) ? KIND_DONE : KIND_ERROR;
        w_final.left  = 16'h0;
        w_final.right = 16'h0;
        w_final.rate  = w_rate_out;
        w_final.err   = w_code;
        w_final.last  = 1'b1;
        o_step.count  = 2'(w_frame_v) + 2'(w_eof);
        o_step.first  = w_frame_v ? w_frame : w_final;
        o_step.second = w_final;
    end

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RIFF;
            r_cnt       <= 2'd0;
            r_shift     <= 32'h0;
            r_rem       <= 32'h0;
            r_format    <= 16'h0;
            r_chan      <= 16'h0;
            r_rate      <= 32'h0;
            r_brate     <= 32'h0;
            r_block     <= 16'h0;
            r_bits      <= 16'h0;
            r_fmt_seen  <= 1'b0;
            r_data_seen <= 1'b0;
            r_low       <= 8'h0;
            r_left      <= 16'h0;
            r_sphase    <= 2'd0;
            r_err       <= ERR_NONE;
        end else begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_shift     <= n_shift;
            r_rem       <= n_rem;
            r_format    <= n_format;
            r_chan      <= n_chan;
            r_rate      <= n_rate;
            r_brate     <= n_brate;
            r_block     <= n_block;
            r_bits      <= n_bits;
            r_fmt_seen  <= n_fmt_seen;
            r_data_seen <= n_data_seen;
            r_low       <= n_low;
            r_left      <= n_left;
            r_sphase    <= n_sphase;
            r_err       <= n_err;
        end
    end

endmodule

FILE: sv/wpp_out_queue.sv
// ----------------------------------------------------------------------------
// WAVE parser result queue
// Three-entry shift queue that takes up to two results per beat and hands
// out one result beat per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module wpp_out_queue
    import wpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_step   i_push,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_room,
    output t_result o_head
);

    t_result    r_q0, r_q1, r_q2;
    t_result    n_q0, n_q1, n_q2;
    logic [1:0] r_count, n_count;
    logic       w_pop;
    logic [1:0] w_base;

    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count < 2'd2);
    assign o_head  = r_q0;
    assign w_pop   = o_valid && i_ready;
    assign w_base  = r_count - 2'(w_pop);

    // Drop the taken head, then append new results behind the rest
    always_comb begin
        n_q0 = w_pop ? r_q1 : r_q0;
        n_q1 = w_pop ? r_q2 : r_q1;
        n_q2 = r_q2;
        if (i_push.count != 2'd0) begin
            case (w_base)
                2'd0:    n_q0 = i_push.first;
                2'd1:    n_q1 = i_push.first;
                default: n_q2 = i_push.first;
            endcase
        end
        if (i_push.count == 2'd2) begin
            case (w_base)
                2'd0:    n_q1 = i_push.second;
                default: n_q2 = i_push.second;
            endcase
        end
        n_count = w_base + i_push.count;
    end

    // Advance the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // Hold queue payload
    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
        r_q2 <= n_q2;
    end

endmodule

FILE: sv/wav_pcm_stream_parser.sv
// ----------------------------------------------------------------------------
// WAVE PCM stream parser: one file byte per beat in, frames and verdict out
// Throughput 1 byte per cycle while o_ready; the queue registers each result.
// The byte that ends a frame and the file gives 2 results, frame then verdict.
// The 3-entry result queue hands out 1 result beat per cycle while i_ready.
// Synchronous active-low reset: expect RIFF tag, all fields clear, queue empty.
// ----------------------------------------------------------------------------
`include "wav_pcm_stream_parser_assert.svh"

module wav_pcm_stream_parser
    import wpp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_item_kind,
    output logic [15:0] o_left_value,
    output logic [15:0] o_right_value,
    output logic [30:0] o_sample_rate,
    output logic [4:0]  o_error_code,
    output logic        o_is_last
);

    logic    w_accept;
    t_step   w_step;
    t_result w_head;

    // Take a byte only while the queue can absorb two results
    assign w_accept = i_valid && o_ready;

    wpp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_file (i_end_of_file),
        .o_step        (w_step)
    );

    wpp_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_step),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_room  (o_ready),
        .o_head  (w_head)
    );

    assign o_item_kind   = w_head.kind;
    assign o_left_value  = w_head.left;
    assign o_right_value = w_head.right;
    assign o_sample_rate = w_head.rate;
    assign o_error_code  = w_head.err;
    assign o_is_last     = w_head.last;

    // Checks
    `WPP_ASSERT_NOW(a_full_has_beat, !o_ready, o_valid)
    `WPP_ASSERT_NEXT(a_eof_gives_beat, w_accept && i_end_of_file, o_valid)
    `WPP_ASSERT_NOW(a_final_is_last, o_valid && o_item_kind != KIND_FRAME, o_is_last)
    `WPP_ASSERT_NOW(a_error_has_code, o_valid && o_item_kind == KIND_ERROR,
                    o_error_code != ERR_NONE)

endmodule

FILE: sim/wav_pcm_stream_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WAVE PCM stream parser testbench
// Streams directed and random WAVE files into the parser one byte per beat,
// well-formed ones with random content and ones broken in every checked way.
// A scoreboard predicts the frames and the verdict of each file and checks
// every result beat in order. Both sides idle at random.
// ----------------------------------------------------------------------------

import wpp_pkg::*;

class wav_frame_checker;
    typedef enum logic [3:0] {
        ST_RIFF, ST_RSIZE, ST_WAVE, ST_CHUNK_ID,
        ST_FMT_SIZE, ST_DATA_SIZE, ST_OTHER_SIZE,
        ST_FORMAT, ST_CHAN, ST_RATE, ST_BRATE, ST_BLOCK, ST_BITS,
        ST_SKIP, ST_DATA, ST_DEAD
    } t_parse_state;

    t_result      pending[$];
    int unsigned  mismatches;
    t_parse_state phase;
    int unsigned  field_count;
    logic [31:0]  field_word;
    logic [31:0]  chunk_left;
    logic [15:0]  fmt_code;
    logic [15:0]  chan_count;
    logic [15:0]  block_size;
    logic [15:0]  sample_bits;
    logic [31:0]  rate_hz;
    logic [31:0]  bytes_per_sec;
    bit           fmt_done;
    bit           data_done;
    logic [7:0]   low_byte;
    logic [15:0]  left_sample;
    logic [1:0]   frame_pos;
    logic [4:0]   first_error;

    function new();
        mismatches = 0;
        clear_file();
    endfunction

    // Return to the start of a file
    function void clear_file();
        phase = ST_RIFF;
        field_count = 0;
        field_word = '0;
        chunk_left = '0;
        fmt_code = '0;
        chan_count = '0;
        block_size = '0;
        sample_bits = '0;
        rate_hz = '0;
        bytes_per_sec = '0;
        fmt_done = 0;
        data_done = 0;
        low_byte = '0;
        left_sample = '0;
        frame_pos = '0;
        first_error = ERR_NONE;
    endfunction

    // Keep the first fault and drop the rest of the file
    function void latch_error(logic [4:0] code);
        if (first_error == ERR_NONE) first_error = code;
        phase = ST_DEAD;
    endfunction

    // Assemble a little-endian field; high once its last byte is in
    function bit gather(logic [7:0] b, int unsigned width);
        if (field_count == 0) field_word = '0;
        field_word |= {24'd0, b} << (8 * field_count);
        if (field_count + 1 >= width) begin
            field_count = 0;
            return 1;
        end
        field_count++;
        return 0;
    endfunction

    function t_result make_item(logic [1:0] kind, logic [15:0] left, logic [15:0] right,
                                logic [30:0] rate, logic [4:0] err);
        t_result r;
        r.kind = kind;
        r.left = left;
        r.right = right;
        r.rate = rate;
        r.err = err;
        r.last = 1'b0;
        return r;
    endfunction

    // Predict the results of one accepted byte beat
    function void note_byte(logic [7:0] b, logic eof);
        t_result      items[$];
        t_parse_state ph;
        logic [15:0]  word;
        logic [15:0]  want_block;
        logic [63:0]  rate_product;
        logic [4:0]   code;
        bit           frame_ok;
        ph = phase;
        frame_ok = 0;
        word = '0;
        case (ph)
            ST_RIFF: begin
                if (gather(b, 4)) begin
                    if (field_word != TAG_RIFF) latch_error(ERR_RIFF_TAG);
                    else phase = ST_RSIZE;
                end
            end
            ST_RSIZE: begin
                if (gather(b, 4)) phase = ST_WAVE;
            end
            ST_WAVE: begin
                if (gather(b, 4)) begin
                    if (field_word != TAG_WAVE) latch_error(ERR_WAVE_TAG);
                    else phase = ST_CHUNK_ID;
                end
            end
            ST_CHUNK_ID: begin
                if (gather(b, 4)) begin
                    if (field_word == TAG_FMT) phase = ST_FMT_SIZE;
                    else if (field_word == TAG_DATA) phase = ST_DATA_SIZE;
                    else phase = ST_OTHER_SIZE;
                end
            end
            ST_FMT_SIZE, ST_DATA_SIZE, ST_OTHER_SIZE: begin
                if (gather(b, 4)) begin
                    if (field_word[31]) begin
                        latch_error(ERR_CHUNK_SIZE);
                    end else if (ph == ST_OTHER_SIZE) begin
                        chunk_left = field_word;
                        phase = (field_word != 0) ? ST_SKIP : ST_CHUNK_ID;
                    end else if (ph == ST_FMT_SIZE) begin
                        if (fmt_done) latch_error(ERR_FMT_DUP);
                        else if (field_word < FMT_MIN_LEN) latch_error(ERR_FMT_SHORT);
                        else begin
                            fmt_done = 1;
                            chunk_left = field_word;
                            phase = ST_FORMAT;
                        end
                    end else if (data_done) begin
                        latch_error(ERR_DATA_DUP);
                    end else if (!fmt_done) begin
                        latch_error(ERR_DATA_EARLY);
                    end else if (sample_bits == 16'd16 && field_word[0]) begin
                        latch_error(ERR_DATA_ODD);
                    end else if ((field_word & ({16'd0, block_size} - 32'd1)) != 0) begin
                        latch_error(ERR_DATA_FRAME);
                    end else begin
                        data_done = 1;
                        chunk_left = field_word;
                        frame_pos = '0;
                        phase = (field_word != 0) ? ST_DATA : ST_CHUNK_ID;
                    end
                end
            end
            ST_FORMAT, ST_CHAN, ST_RATE, ST_BRATE, ST_BLOCK, ST_BITS: begin
                chunk_left--;
                if (gather(b, (ph == ST_RATE || ph == ST_BRATE) ? 4 : 2)) begin
                    case (ph)
                        ST_FORMAT: fmt_code = field_word[15:0];
                        ST_CHAN:   chan_count = field_word[15:0];
                        ST_RATE:   rate_hz = field_word;
                        ST_BRATE:  bytes_per_sec = field_word;
                        ST_BLOCK:  block_size = field_word[15:0];
                        default:   sample_bits = field_word[15:0];
                    endcase
                    want_block = chan_count * (sample_bits >> 3);
                    rate_product = {32'd0, rate_hz} * {48'd0, block_size};
                    // Validate the format as soon as its last field is in
                    if (ph != ST_BITS) phase = ph.next();
                    else if (fmt_code != 16'd1) latch_error(ERR_FORMAT);
                    else if (chan_count < 16'd1 || chan_count > 16'd2) latch_error(ERR_CHANNELS);
                    else if (rate_hz == 0 || rate_hz[31]) latch_error(ERR_RATE);
                    else if (sample_bits != 16'd8 && sample_bits != 16'd16)
                        latch_error(ERR_BITS);
                    else if (block_size != want_block) latch_error(ERR_BLOCK);
                    else if ({32'd0, bytes_per_sec} != rate_product) latch_error(ERR_BYTE_RATE);
                    else phase = (chunk_left != 0) ? ST_SKIP : ST_CHUNK_ID;
                end
            end
            ST_SKIP: begin
                chunk_left--;
                if (chunk_left == 0) phase = ST_CHUNK_ID;
            end
            ST_DATA: begin
                chunk_left--;
                if (sample_bits == 16'd8) begin
                    word = {b, 8'h00};
                    if (chan_count == 16'd1) frame_ok = 1;
                    else if (frame_pos == 0) begin
                        left_sample = word;
                        frame_pos = 2'd1;
                    end else begin
                        frame_pos = 2'd0;
                        frame_ok = 1;
                    end
                end else if (!frame_pos[0]) begin
                    low_byte = b;
                    frame_pos = frame_pos + 2'd1;
                end else begin
                    word = {b, low_byte} ^ SIGN_FLIP;
                    if (chan_count == 16'd1) begin
                        frame_pos = 2'd0;
                        frame_ok = 1;
                    end else if (frame_pos == 2'd1) begin
                        left_sample = word;
                        frame_pos = 2'd2;
                    end else begin
                        frame_pos = 2'd0;
                        frame_ok = 1;
                    end
                end
                if (frame_ok)
                    items.push_back(make_item(KIND_FRAME,
                        (chan_count == 16'd1) ? word : left_sample, word, '0, ERR_NONE));
                if (chunk_left == 0) phase = ST_CHUNK_ID;
            end
            default: ;
        endcase

        // Give the verdict on the last byte of the file
        if (eof) begin
            code = first_error;
            if (code == ERR_NONE) begin
                if (phase != ST_CHUNK_ID || field_count != 0) code = ERR_TRUNCATED;
                else if (!data_done) code = ERR_NO_DATA;
            end
            if (code != ERR_NONE) items.push_back(make_item(KIND_ERROR, '0, '0, '0, code));
            else items.push_back(make_item(KIND_DONE, '0, '0, rate_hz[30:0], ERR_NONE));
            clear_file();
        end
        if (items.size() > 0) items[items.size() - 1].last = 1'b1;
        foreach (items[i]) pending.push_back(items[i]);
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_result(t_result got);
        t_result want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind %0d left %h right %h rate %0d err %0d last %0d",
                         got.kind, got.left, got.right, got.rate, got.err, got.last);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch expected: kind %0d left %h right %h rate %0d err %0d last %0d",
                         want.kind, want.left, want.right, want.rate, want.err, want.last);
                $display("         actual:   kind %0d left %h right %h rate %0d err %0d last %0d",
                         got.kind, got.left, got.right, got.rate, got.err, got.last);
            end
        end
    endfunction
endclass

module wav_pcm_stream_parser_tb;
    localparam int BYTE_TARGET = 1100;
    localparam int STALL_LIMIT = 1000;

    // Ways to build a file; each broken kind aims at one fault
    typedef enum int {
        FAULT_NONE, FAULT_RIFF_TAG, FAULT_WAVE_TAG, FAULT_CHUNK_SIZE, FAULT_FMT_DUP,
        FAULT_FMT_SHORT, FAULT_DATA_DUP, FAULT_DATA_EARLY, FAULT_FORMAT, FAULT_CHANNELS,
        FAULT_RATE, FAULT_BITS, FAULT_BLOCK, FAULT_BYTE_RATE, FAULT_NO_DATA,
        FAULT_DATA_ODD, FAULT_DATA_FRAME, FAULT_TRUNC, FAULT_NOISE, FAULT_COUNT
    } t_fault;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_ready;
    logic [7:0]  file_byte = '0;
    logic        last_byte = 1'b0;
    logic        item_valid;
    logic        item_ready = 1'b0;
    logic [1:0]  item_kind;
    logic [15:0] left_value;
    logic [15:0] right_value;
    logic [30:0] sample_rate;
    logic [4:0]  error_code;
    logic        item_last;

    wav_frame_checker parse_check;
    logic [7:0]       file_bytes[$];
    int unsigned      bytes_sent = 0;
    int unsigned      idle_cycles = 0;
    bit               source_idles = 0;
    bit               sink_idles = 0;

    wav_pcm_stream_parser i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (byte_valid),
        .o_ready       (byte_ready),
        .i_in_byte     (file_byte),
        .i_end_of_file (last_byte),
        .o_valid       (item_valid),
        .i_ready       (item_ready),
        .o_item_kind   (item_kind),
        .o_left_value  (left_value),
        .o_right_value (right_value),
        .o_sample_rate (sample_rate),
        .o_error_code  (error_code),
        .o_is_last     (item_last)
    );

    always #2 clk = ~clk;

    // Stop the run when no beat moves for too long
    always @(posedge clk) begin
        if (!rst_n || (byte_valid && byte_ready) || (item_valid && item_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void put_le(logic [31:0] value, int unsigned count);
        for (int i = 0; i < count; i++) file_bytes.push_back(value[8*i +: 8]);
    endfunction

    function automatic void put_random(int unsigned count);
        repeat (count) file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_chunk(logic [31:0] tag, logic [31:0] size, int unsigned body);
        put_le(tag, 4);
        put_le(size, 4);
        put_random(body);
    endfunction

    // Chunk id that is neither fmt nor data, often one bit away from them
    function automatic logic [31:0] other_tag();
        logic [31:0] id;
        case ($urandom_range(0, 3))
            0:       id = TAG_FMT ^ (32'd1 << $urandom_range(0, 31));
            1:       id = TAG_DATA ^ (32'd1 << $urandom_range(0, 31));
            default: id = $urandom;
        endcase
        if (id == TAG_FMT || id == TAG_DATA) id = ~id;
        return id;
    endfunction

    function automatic void put_other_chunks(bit huge);
        int unsigned size;
        repeat ($urandom_range(0, 2)) begin
            size = $urandom_range(0, 6);
            put_chunk(other_tag(), size, size);
        end
        if (huge) put_chunk(other_tag(), $urandom_range(32'h8000_0000, 32'hFFFF_FFFF),
                            $urandom_range(0, 3));
    endfunction

    // Build one file into file_bytes
    function automatic void build_file(t_fault fault);
        logic [15:0] fmt_code;
        logic [15:0] chans;
        logic [15:0] bits;
        logic [15:0] blk;
        logic [31:0] rate;
        logic [31:0] brate;
        logic [31:0] data_len;
        logic [31:0] fmt_len;
        int unsigned frames;
        int unsigned cut;
        file_bytes.delete();
        if (fault == FAULT_NOISE) begin
            if ($urandom_range(0, 1)) put_le(TAG_RIFF, 4);
            put_random($urandom_range(1, 40));
            return;
        end

        fmt_code = 16'd1;
        chans = 16'($urandom_range(1, 2));
        bits = $urandom_range(0, 1) ? 16'd16 : 16'd8;
        case ($urandom_range(0, 9))
            0:       rate = 32'd1;
            1, 2:    rate = $urandom_range(1, 32'h3FFF_FFFF);
            default: rate = $urandom_range(8000, 96000);
        endcase
        // Largest rate only fits the byte rate with one-byte frames
        if ($urandom_range(0, 9) == 0) begin
            chans = 16'd1;
            bits = 16'd8;
            rate = 32'h7FFF_FFFF;
        end
        if (fault == FAULT_DATA_ODD) bits = 16'd16;
        if (fault == FAULT_DATA_FRAME) chans = 16'd2;
        case (fault)
            FAULT_FORMAT:   fmt_code = $urandom_range(0, 1) ? 16'd0 :
                                       16'($urandom_range(2, 16'hFFFF));
            FAULT_CHANNELS: chans = $urandom_range(0, 1) ? 16'd0 :
                                    16'($urandom_range(3, 16'hFFFF));
            FAULT_RATE:     rate = $urandom_range(0, 1) ? 32'd0 :
                                   $urandom_range(32'h8000_0000, 32'hFFFF_FFFF);
            FAULT_BITS: begin
                bits = 16'($urandom_range(0, 16'hFFFF));
                if (bits == 16'd8 || bits == 16'd16) bits = 16'd24;
            end
            default: ;
        endcase
        blk = chans * (bits >> 3);
        brate = rate * blk;
        if (fault == FAULT_BLOCK) blk = blk + 16'($urandom_range(1, 16'hFFFF));
        if (fault == FAULT_BYTE_RATE) brate = brate ^ $urandom_range(1, 32'hFFFF_FFFF);

        frames = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6);
        data_len = frames * blk;
        // Keep the ignored data of a bad format short
        if (fault >= FAULT_FORMAT && fault <= FAULT_BYTE_RATE) data_len = frames;
        if (fault == FAULT_DATA_ODD) data_len = data_len + 1;
        if (fault == FAULT_DATA_FRAME) data_len = data_len + ((bits == 16'd8) ? 1 : 2);
        fmt_len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 20) : 16;
        if (fault == FAULT_FMT_SHORT) fmt_len = $urandom_range(0, 15);

        put_le((fault == FAULT_RIFF_TAG) ? TAG_RIFF ^ (32'd1 << $urandom_range(0, 31))
                                         : TAG_RIFF, 4);
        put_le($urandom, 4);
        put_le((fault == FAULT_WAVE_TAG) ? TAG_WAVE ^ (32'd1 << $urandom_range(0, 31))
                                         : TAG_WAVE, 4);
        if (fault == FAULT_DATA_EARLY) put_chunk(TAG_DATA, data_len, data_len);
        put_other_chunks(fault == FAULT_CHUNK_SIZE);
        repeat ((fault == FAULT_FMT_DUP) ? 2 : 1) begin
            put_le(TAG_FMT, 4);
            put_le(fmt_len, 4);
            put_le(32'(fmt_code), 2);
            put_le(32'(chans), 2);
            put_le(rate, 4);
            put_le(brate, 4);
            put_le(32'(blk), 2);
            put_le(32'(bits), 2);
            if (fmt_len > 16) put_random(fmt_len - 16);
        end
        put_other_chunks(0);
        if (fault != FAULT_NO_DATA)
            repeat ((fault == FAULT_DATA_DUP) ? 2 : 1) put_chunk(TAG_DATA, data_len, data_len);
        if ($urandom_range(0, 3) == 0) put_chunk(other_tag(), 2, 2);

        // End the file inside a field or a chunk
        if (fault == FAULT_TRUNC) begin
            if ($urandom_range(0, 1)) begin
                cut = $urandom_range(1, 12);
                repeat (cut) void'(file_bytes.pop_back());
            end else begin
                put_random($urandom_range(1, 7));
            end
        end
    endfunction

    // Offer one byte beat after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] value, input logic eof);
        int unsigned gap;
        gap = source_idles ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        file_byte <= value;
        last_byte <= eof;
        do @(posedge clk); while (!byte_ready);
        parse_check.note_byte(value, eof);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // Hold the input until every predicted result has come out
    task automatic wait_drained();
        byte_valid <= 1'b0;
        do @(posedge clk); while (parse_check.pending.size() != 0);
    endtask

    // Take result beats with random stalls
    initial begin : result_sink
        int unsigned stall;
        t_result     got;
        wait (rst_n);
        forever begin
            if ($urandom_range(0, 31) == 0) sink_idles = !sink_idles;
            stall = sink_idles ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                item_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            item_ready <= 1'b1;
            do @(posedge clk); while (!item_valid);
            got = {item_kind, left_value, right_value, sample_rate, error_code, item_last};
            parse_check.check_result(got);
        end
    end

    initial begin : stimulus
        t_fault fault;
        parse_check = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // End of file on the very first byte
        file_bytes.delete();
        put_le(32'h0000_0052, 1);
        send_file();
        // Bad RIFF tag; the bytes after it are ignored
        file_bytes.delete();
        put_le(32'h5846_4952, 4);
        put_le(32'h0000_00FF, 2);
        send_file();
        // Header alone with the largest RIFF size: neither fmt nor data
        file_bytes.delete();
        put_le(TAG_RIFF, 4);
        put_le(32'hFFFF_FFFF, 4);
        put_le(TAG_WAVE, 4);
        send_file();

        // Go once through every kind of file, then mostly well-formed ones
        for (int f = 0; bytes_sent < BYTE_TARGET || f < FAULT_COUNT; f++) begin
            if (f < FAULT_COUNT) fault = t_fault'(f);
            else if ($urandom_range(0, 1)) fault = FAULT_NONE;
            else fault = t_fault'($urandom_range(0, FAULT_COUNT - 1));
            source_idles = ($urandom_range(0, 3) != 0);
            build_file(fault);
            send_file();
            if (f == 2 || $urandom_range(0, 7) == 0) wait_drained();
        end

        byte_valid <= 1'b0;
        do @(posedge clk); while (parse_check.pending.size() != 0);
        repeat (8) @(posedge clk);
        if (parse_check.mismatches == 0 && parse_check.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: wav_pcm_stream_parser.f
+incdir+sv
sv/wpp_pkg.sv
sv/wpp_parser.sv
sv/wpp_out_queue.sv
sv/wav_pcm_stream_parser.sv
sim/wav_pcm_stream_parser_tb.sv
